FILE: rtl/core/pinned_pixel_flow_tracker_core_defines.svh
// ----------------------------------------------------------------------------
// Pinned pixel flow tracker: assertion macros
// Shared concurrent assertion forms used by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef PINNED_PIXEL_FLOW_TRACKER_CORE_DEFINES_SVH
`define PINNED_PIXEL_FLOW_TRACKER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPFT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ppft_pkg.sv
// ----------------------------------------------------------------------------
// Pinned pixel flow tracker package
// Types, codes and constants shared by the tracker modules.
// ----------------------------------------------------------------------------
package ppft_pkg;

    // Default table sizes.
    localparam int WELLS_DEFAULT = 65536;
    localparam int FLOWS_DEFAULT = 512;

    // Field widths.
    localparam int KIND_W     = 2;
    localparam int WELL_IDX_W = 16;
    localparam int FLOW_W     = 9;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int THRESH_W   = 14;
    localparam int COUNT_W    = 17;

    // Largest table depths the field widths can address.
    localparam int WELL_SPACE = 1 << WELL_IDX_W;
    localparam int FLOW_SPACE = 1 << FLOW_W;

    // Gain correction arithmetic.
    localparam int FRAC_BITS  = 12;
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int QUOT_W     = PROD_W - FRAC_BITS;
    localparam int CLAMP_HIGH = 16383;
    localparam int SAT_LOW    = -32768;

    // Threshold reset values.
    localparam logic [THRESH_W-1:0] PIN_HIGH_RESET = 14'h3fff;
    localparam logic [THRESH_W-1:0] PIN_LOW_RESET  = 14'h0000;

    // Count saturation value.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Queue depths.
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // Configuration register indexes.
    localparam logic CFG_PIN_HIGH = 1'b0;
    localparam logic CFG_PIN_LOW  = 1'b1;

    // Item kinds on the input.
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESET = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // Operation the back end carries out.
    typedef enum logic [1:0] {
        OP_QUERY,
        OP_PRESET,
        OP_PIN
    } op_t;

    // Back end sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EVAL  = 4'b0100,
        ST_DEC   = 4'b1000
    } back_state_t;

    // Input item.
    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [WELL_IDX_W-1:0]      well_index;
        logic [FLOW_W-1:0]          flow;
        logic signed [SAMPLE_W-1:0] sample;
        logic [GAIN_W-1:0]          gain;
        logic                       preset_pinned;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] corrected_sample;
        logic                       out_of_range;
        logic [COUNT_W-1:0]         flow_pin_count;
        logic                       well_pinned;
        logic [FLOW_W-1:0]          first_flow;
    } result_t;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        op_t                        op;
        logic [WELL_IDX_W-1:0]      well_index;
        logic                       well_ok;
        logic [FLOW_W-1:0]          flow;
        logic                       flow_ok;
        logic signed [SAMPLE_W-1:0] corrected_sample;
        logic                       out_of_range;
        logic                       preset_pinned;
    } work_item_t;

    // Entry of the first pin table.
    typedef struct packed {
        logic              valid;
        logic [FLOW_W-1:0] flow;
    } pin_entry_t;

endpackage

FILE: rtl/core/ppft_ram.sv
// ----------------------------------------------------------------------------
// Pinned pixel flow tracker: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ppft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/ppft_fifo.sv
// ----------------------------------------------------------------------------
// Pinned pixel flow tracker: small queue
// Register-based first-in first-out queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ppft_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots need no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/core/ppft_front.sv
// ----------------------------------------------------------------------------
// Pinned pixel flow tracker: front end
// Accepts items, applies the gain, checks the pin thresholds and classifies
// each item into the operation that the back end performs.
// ----------------------------------------------------------------------------
module ppft_front import ppft_pkg::*; #(
    parameter int WELLS = WELLS_DEFAULT,
    parameter int FLOWS = FLOWS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [THRESH_W-1:0] cfg_data,
    input  logic                push,
    input  in_item_t            item,
    output logic                full,
    input  logic                hold,
    output logic                mid_push,
    output work_item_t          mid_item,
    input  logic                mid_full
);

    logic [THRESH_W-1:0]      pin_high_reg;
    logic [THRESH_W-1:0]      pin_low_reg;
    logic                     valid_reg, valid_next;
    logic [KIND_W-1:0]        kind_reg;
    logic [WELL_IDX_W-1:0]    well_reg;
    logic [FLOW_W-1:0]        flow_reg;
    logic                     preset_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     accept;
    logic                     round_up;
    logic signed [QUOT_W-1:0] quot;
    logic signed [SAMPLE_W-1:0] clamped;
    logic signed [COUNT_W-1:0]  value_ext;
    logic signed [COUNT_W-1:0]  low_ext;
    logic signed [COUNT_W-1:0]  high_ext;
    logic                     hit;
    logic                     well_ok;
    logic                     flow_ok;

    // Threshold registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_high_reg <= PIN_HIGH_RESET;
            pin_low_reg  <= PIN_LOW_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_PIN_HIGH)
            begin
                pin_high_reg <= cfg_data;
            end
            else
            begin
                pin_low_reg <= cfg_data;
            end
        end
    end

    // Input handshake: the stage moves on when the queue takes its item.
    assign full     = hold || (valid_reg && mid_full);
    assign accept   = push && !full;
    assign mid_push = valid_reg && !mid_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (mid_push)
        begin
            valid_next = 1'b0;
        end
    end

    // Signed sample times unsigned Q4.12 gain.
    assign prod_next = PROD_W'(item.sample) * PROD_W'($signed({1'b0, item.gain}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= item.kind;
            well_reg   <= item.well_index;
            flow_reg   <= item.flow;
            preset_reg <= item.preset_pinned;
            prod_reg   <= prod_next;
        end
    end

    // Drop the fraction toward zero: a negative product with fraction bits
    // set is one above its floor.
    assign round_up = prod_reg[PROD_W-1] && (prod_reg[FRAC_BITS-1:0] != '0);
    assign quot     = $signed(prod_reg[PROD_W-1:FRAC_BITS])
                    + $signed({{(QUOT_W-1){1'b0}}, round_up});

    // Clamp high and saturate low.
    always_comb
    begin
        if (quot > QUOT_W'(CLAMP_HIGH))
        begin
            clamped = SAMPLE_W'(CLAMP_HIGH);
        end
        else if (quot < QUOT_W'(SAT_LOW))
        begin
            clamped = SAMPLE_W'(SAT_LOW);
        end
        else
        begin
            clamped = quot[SAMPLE_W-1:0];
        end
    end

    // Threshold test in a width that holds both signs.
    assign value_ext = COUNT_W'(clamped);
    assign low_ext   = $signed({{(COUNT_W-THRESH_W){1'b0}}, pin_low_reg});
    assign high_ext  = $signed({{(COUNT_W-THRESH_W){1'b0}}, pin_high_reg});
    assign hit       = (value_ext <= low_ext) || (value_ext >= high_ext);

    assign well_ok = (32'(well_reg) < WELLS);
    assign flow_ok = (32'(flow_reg) < FLOWS);

    // Classification into the back end operation.
    always_comb
    begin
        mid_item.well_index       = well_reg;
        mid_item.well_ok          = well_ok;
        mid_item.flow             = flow_reg;
        mid_item.flow_ok          = flow_ok;
        mid_item.preset_pinned    = preset_reg;
        mid_item.corrected_sample = '0;
        mid_item.out_of_range     = 1'b0;
        mid_item.op               = OP_QUERY;
        case (kind_reg)
            KIND_SAMPLE:
            begin
                mid_item.corrected_sample = clamped;
                mid_item.out_of_range     = hit;
                if (hit && well_ok && flow_ok)
                begin
                    mid_item.op = OP_PIN;
                end
            end
            KIND_PRESET:
            begin
                if (well_ok)
                begin
                    mid_item.op = OP_PRESET;
                end
            end
            default:
            begin
                mid_item.op = OP_QUERY;
            end
        endcase
    end

endmodule

FILE: rtl/core/ppft_back.sv
// ----------------------------------------------------------------------------
// Pinned pixel flow tracker: back end
// Clears the tables after reset, then runs the read-modify-write of the first
// pin table and the per-flow pin counts for one item at a time.
// ----------------------------------------------------------------------------
`include "pinned_pixel_flow_tracker_core_defines.svh"

module ppft_back import ppft_pkg::*; #(
    parameter int WELLS = WELLS_DEFAULT,
    parameter int FLOWS = FLOWS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    output logic       clearing,
    input  logic       mid_empty,
    input  work_item_t mid_item,
    output logic       mid_pop,
    output logic       out_push,
    output result_t    out_item,
    input  logic       out_full
);

    localparam int WELL_DEPTH = (WELLS < WELL_SPACE) ? WELLS : WELL_SPACE;
    localparam int FLOW_DEPTH = (FLOWS < FLOW_SPACE) ? FLOWS : FLOW_SPACE;
    localparam int WELL_AW    = (WELL_DEPTH > 1) ? $clog2(WELL_DEPTH) : 1;
    localparam int FLOW_AW    = (FLOW_DEPTH > 1) ? $clog2(FLOW_DEPTH) : 1;
    localparam int SWEEP      = (WELL_DEPTH > FLOW_DEPTH) ? WELL_DEPTH : FLOW_DEPTH;
    localparam int CLR_W      = (WELL_AW > FLOW_AW) ? WELL_AW : FLOW_AW;

    back_state_t        state_reg, state_next;
    logic [CLR_W-1:0]   clr_reg, clr_next;
    work_item_t         cur_reg, cur_next;
    logic [FLOW_W-1:0]  old_flow_reg, old_flow_next;

    logic               well_we;
    logic [WELL_AW-1:0] well_waddr;
    pin_entry_t         well_wdata;
    logic [WELL_AW-1:0] well_raddr;
    pin_entry_t         well_rdata;
    logic               cnt_we;
    logic [FLOW_AW-1:0] cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [FLOW_AW-1:0] cnt_raddr;
    logic [COUNT_W-1:0] cnt_rdata;

    pin_entry_t         entry_rd;
    logic [COUNT_W-1:0] count_rd;
    logic [COUNT_W-1:0] count_inc;
    logic               pin_upd;
    logic               need_dec;
    pin_entry_t         entry_out;

    ppft_ram #(
        .WIDTH ($bits(pin_entry_t)),
        .DEPTH (WELL_DEPTH)
    ) u_first_pin (
        .clk   (clk),
        .we    (well_we),
        .waddr (well_waddr),
        .wdata (well_wdata),
        .raddr (well_raddr),
        .rdata (well_rdata)
    );

    ppft_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (FLOW_DEPTH)
    ) u_pin_count (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Table contents as seen by the current item; out-of-range indexes read
    // as never pinned and a zero count.
    assign entry_rd  = cur_reg.well_ok ? well_rdata : '0;
    assign count_rd  = cur_reg.flow_ok ? cnt_rdata : '0;
    assign count_inc = (count_rd == COUNT_MAX) ? count_rd : count_rd + 1'b1;
    assign pin_upd   = (cur_reg.op == OP_PIN)
                    && (!entry_rd.valid || (entry_rd.flow > cur_reg.flow));
    // Stored flows were in range when written, so only flow zero is exempt.
    assign need_dec  = pin_upd && entry_rd.valid && (entry_rd.flow != '0);

    // Entry after this item's update.
    always_comb
    begin
        entry_out = entry_rd;
        case (cur_reg.op)
            OP_PIN:
            begin
                if (pin_upd)
                begin
                    entry_out.valid = 1'b1;
                    entry_out.flow  = cur_reg.flow;
                end
            end
            OP_PRESET:
            begin
                entry_out.valid = cur_reg.preset_pinned;
                entry_out.flow  = '0;
            end
            default:
            begin
                entry_out = entry_rd;
            end
        endcase
    end

    // Result of the current item.
    assign out_item.corrected_sample = cur_reg.corrected_sample;
    assign out_item.out_of_range     = cur_reg.out_of_range;
    assign out_item.flow_pin_count   = pin_upd ? count_inc : count_rd;
    assign out_item.well_pinned      = entry_out.valid;
    assign out_item.first_flow       = entry_out.valid ? entry_out.flow : '0;

    assign clearing = (state_reg == ST_CLEAR);

    // Sequencer: clear sweep, then fetch, evaluate and optional decrement.
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cur_next      = cur_reg;
        old_flow_next = old_flow_reg;
        mid_pop       = 1'b0;
        out_push      = 1'b0;
        well_we       = 1'b0;
        well_waddr    = cur_reg.well_index[WELL_AW-1:0];
        well_wdata    = entry_out;
        well_raddr    = mid_item.well_index[WELL_AW-1:0];
        cnt_we        = 1'b0;
        cnt_waddr     = cur_reg.flow[FLOW_AW-1:0];
        cnt_wdata     = count_inc;
        cnt_raddr     = mid_item.flow[FLOW_AW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                well_we    = (32'(clr_reg) < WELL_DEPTH);
                well_waddr = clr_reg[WELL_AW-1:0];
                well_wdata = '0;
                cnt_we     = (32'(clr_reg) < FLOW_DEPTH);
                cnt_waddr  = clr_reg[FLOW_AW-1:0];
                cnt_wdata  = '0;
                if (clr_reg == CLR_W'(SWEEP - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                // Reads are issued from the queue head.
                if (!mid_empty && !out_full)
                begin
                    mid_pop    = 1'b1;
                    cur_next   = mid_item;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                out_push = 1'b1;
                if (pin_upd || (cur_reg.op == OP_PRESET))
                begin
                    well_we = 1'b1;
                end
                if (pin_upd)
                begin
                    cnt_we = 1'b1;
                end
                if (need_dec)
                begin
                    cnt_raddr     = entry_rd.flow[FLOW_AW-1:0];
                    old_flow_next = entry_rd.flow;
                    state_next    = ST_DEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DEC:
            begin
                // The old flow's count drops by one and holds at zero.
                cnt_waddr  = old_flow_reg[FLOW_AW-1:0];
                cnt_wdata  = cnt_rdata - 1'b1;
                cnt_we     = (cnt_rdata != '0);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        old_flow_reg <= old_flow_next;
    end

    // Checks on the sequencer.
    `PPFT_ASSERT_SAME(a_no_push_in_clear, clk, rst_n, state_reg == ST_CLEAR, !out_push, "result during table clear")
    `PPFT_ASSERT_SAME(a_push_has_room, clk, rst_n, out_push, !out_full, "result pushed into a full output queue")
    `PPFT_ASSERT_SAME(a_push_after_pop, clk, rst_n, out_push, $past(mid_pop), "result without a fetched item")
    `PPFT_ASSERT_NEXT(a_dec_one_cycle, clk, rst_n, state_reg == ST_DEC, state_reg == ST_IDLE, "decrement did not finish")

endmodule

FILE: rtl/core/pinned_pixel_flow_tracker_core.sv
// The back end takes one item at a time for the table read-modify-write through
// registered single reads, with a decrement step when a pin moves a well to an
// earlier flow. Reset: thresholds return to 16383 and 0; a clearing pass zeroes
// both tables while full stays high.
// ----------------------------------------------------------------------------
// Pinned pixel flow tracker core
// Gain-corrects sensor samples, detects pinned wells and keeps the earliest
// pin flow per well together with a pin count per flow.
// ----------------------------------------------------------------------------
module pinned_pixel_flow_tracker_core import ppft_pkg::*; #(
    parameter int WELLS = WELLS_DEFAULT,
    parameter int FLOWS = FLOWS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [THRESH_W-1:0] cfg_data,
    input  logic                push,
    input  in_item_t            item,
    output logic                full,
    input  logic                pop,
    output result_t             result,
    output logic                empty
);

    logic       clearing;
    logic       mid_push;
    work_item_t mid_wr_item;
    logic       mid_full;
    logic       mid_pop;
    work_item_t mid_rd_item;
    logic       mid_empty;
    logic       out_push;
    result_t    out_wr_item;
    logic       out_full;
    logic [$bits(work_item_t)-1:0] mid_rdata;
    logic [$bits(result_t)-1:0]    out_rdata;

    // Front end: gain, thresholds and classification.
    ppft_front #(
        .WELLS (WELLS),
        .FLOWS (FLOWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .full      (full),
        .hold      (clearing),
        .mid_push  (mid_push),
        .mid_item  (mid_wr_item),
        .mid_full  (mid_full)
    );

    // Queue between front and back ends.
    ppft_fifo #(
        .WIDTH ($bits(work_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wr_item),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign mid_rd_item = work_item_t'(mid_rdata);

    // Back end: table updates.
    ppft_back #(
        .WELLS (WELLS),
        .FLOWS (FLOWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .mid_empty (mid_empty),
        .mid_item  (mid_rd_item),
        .mid_pop   (mid_pop),
        .out_push  (out_push),
        .out_item  (out_wr_item),
        .out_full  (out_full)
    );

    // Result queue toward the consumer.
    ppft_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wr_item),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign result = result_t'(out_rdata);

endmodule

FILE: dv/tb_pinned_pixel_flow_tracker_core.sv
// ----------------------------------------------------------------------------
// Pinned pixel flow tracker core testbench
// Drives sample, preset, query and unused-kind items into the core and checks
// every result against an in-bench model of the gain correction, the pin
// thresholds, the per-well first pin flow and the per-flow pin counts.
// ----------------------------------------------------------------------------
module tb_pinned_pixel_flow_tracker_core import ppft_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Bench constants.
    localparam logic [KIND_W-1:0] KIND_UNUSED     = 2'd3;
    localparam logic [GAIN_W-1:0] UNITY_GAIN      = 16'd4096;
    localparam logic [15:0]       WELL_POOL_BASE  = 16'h0100;
    localparam logic [15:0]       SWEEP_WELL_BASE = 16'h4000;
    localparam int                DRAIN_CYCLES    = 8;
    localparam int unsigned       QUIET_LIMIT     = 200000;
    localparam int                MAX_PRINTED     = 30;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic                cfg_index;
    logic [THRESH_W-1:0] cfg_data;
    logic                push;
    in_item_t            in_item;
    logic                full;
    logic                pop;
    result_t             out_result;
    logic                empty;

    // Model state: thresholds, first pin flow per well, pin count per flow.
    logic [THRESH_W-1:0] pin_high_thr;
    logic [THRESH_W-1:0] pin_low_thr;
    pin_entry_t          first_pin [WELLS_DEFAULT];
    logic [COUNT_W-1:0]  flow_pins [FLOWS_DEFAULT];

    result_t     pending_results[$];
    int          mismatch_count;
    int          items_sent;
    int          results_checked;
    int          threshold_writes;
    int          earlier_moves;
    int unsigned quiet_cycles;
    bit          sender_idles;
    bit          receiver_stalls;

    pinned_pixel_flow_tracker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (in_item),
        .full      (full),
        .pop       (pop),
        .result    (out_result),
        .empty     (empty)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Gain correction: Q4.12 product truncated toward zero, then clamped.
    function automatic int gain_corrected(logic signed [SAMPLE_W-1:0] s,
                                          logic [GAIN_W-1:0] g);
        longint prod;
        longint q;
        prod = longint'(s) * longint'(g);
        q = prod / 4096;
        if (q > CLAMP_HIGH)
            q = CLAMP_HIGH;
        if (q < SAT_LOW)
            q = SAT_LOW;
        return int'(q);
    endfunction

    // Updates the tables for one accepted item and returns its result.
    function automatic result_t predict_result(in_item_t it);
        result_t    r;
        pin_entry_t cur;
        int         corr;
        int         lo;
        int         hi;
        r = '0;
        lo = pin_low_thr;
        hi = pin_high_thr;
        if (it.kind == KIND_SAMPLE)
        begin
            corr = gain_corrected(it.sample, it.gain);
            r.corrected_sample = corr[15:0];
            r.out_of_range = (corr <= lo) || (corr >= hi);
            if (r.out_of_range)
            begin
                cur = first_pin[it.well_index];
                if (!cur.valid || cur.flow > it.flow)
                begin
                    first_pin[it.well_index] = {1'b1, it.flow};
                    if (flow_pins[it.flow] != COUNT_MAX)
                        flow_pins[it.flow] = flow_pins[it.flow] + 1'b1;
                    if (cur.valid && cur.flow != '0 && flow_pins[cur.flow] != '0)
                    begin
                        flow_pins[cur.flow] = flow_pins[cur.flow] - 1'b1;
                        earlier_moves++;
                    end
                end
            end
        end
        else if (it.kind == KIND_PRESET)
        begin
            first_pin[it.well_index] = it.preset_pinned ? {1'b1, {FLOW_W{1'b0}}} : '0;
        end
        cur = first_pin[it.well_index];
        r.flow_pin_count = flow_pins[it.flow];
        r.well_pinned = cur.valid;
        r.first_flow = cur.valid ? cur.flow : '0;
        return r;
    endfunction

    function automatic in_item_t make_item(logic [KIND_W-1:0] k, logic [15:0] w,
                                           logic [FLOW_W-1:0] f,
                                           logic signed [SAMPLE_W-1:0] s,
                                           logic [GAIN_W-1:0] g, logic p);
        in_item_t it;
        it.kind = k;
        it.well_index = w;
        it.flow = f;
        it.sample = s;
        it.gain = g;
        it.preset_pinned = p;
        return it;
    endfunction

    // Unity-gain sample strictly between the current thresholds or, when pinned, on or beyond one of them.
    function automatic in_item_t flow_sample(logic [15:0] w, logic [FLOW_W-1:0] f,
                                             bit pinned);
        int lvl;
        if (!pinned)
            lvl = $urandom_range(int'(pin_high_thr) - 1, int'(pin_low_thr) + 1);
        else if ($urandom_range(1))
            lvl = int'(pin_low_thr) - int'($urandom_range(50));
        else
            lvl = int'(pin_high_thr) + int'($urandom_range(3));
        return make_item(KIND_SAMPLE, w, f, lvl[15:0], UNITY_GAIN,
                         1'($urandom_range(1)));
    endfunction

    // Random item, mostly on a small pool of wells and early flows.
    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned pick;
        int          lvl;
        pick = $urandom_range(99);
        if (pick < 55)
            it.kind = KIND_SAMPLE;
        else if (pick < 70)
            it.kind = KIND_PRESET;
        else if (pick < 92)
            it.kind = KIND_QUERY;
        else
            it.kind = KIND_UNUSED;
        pick = $urandom_range(99);
        if (pick < 80)
            it.well_index = WELL_POOL_BASE + 16'($urandom_range(15));
        else if (pick < 95)
            it.well_index = 16'($urandom);
        else
            it.well_index = $urandom_range(1) ? '1 : '0;
        pick = $urandom_range(99);
        if (pick < 70)
            it.flow = 9'($urandom_range(31));
        else if (pick < 95)
            it.flow = 9'($urandom);
        else
            it.flow = '1;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            lvl = ($urandom_range(1) ? int'(pin_low_thr) : int'(pin_high_thr))
                  + int'($urandom_range(4)) - 2;
            it.sample = lvl[15:0];
            it.gain = UNITY_GAIN;
        end
        else
        begin
            it.sample = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 40)
                it.gain = UNITY_GAIN;
            else if (pick < 80)
                it.gain = 16'($urandom);
            else if (pick < 90)
                it.gain = '0;
            else
                it.gain = '1;
        end
        it.preset_pinned = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Sends one item, with random idle cycles ahead of it when sender_idles is set, and
    // records the expected result at the edge where the transfer happens.
    task automatic send_item(input in_item_t it);
        @(negedge clk);
        if (sender_idles)
        begin
            while ($urandom_range(99) < 20)
            begin
                push <= 1'b0;
                @(negedge clk);
            end
        end
        push <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_results.push_back(predict_result(it));
        items_sent++;
    endtask

    // Stops sending and waits until every expected result has been taken.
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic idx, input logic [THRESH_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_PIN_HIGH)
            pin_high_thr = value;
        else
            pin_low_thr = value;
        threshold_writes++;
    endtask

    task automatic set_thresholds(input logic [THRESH_W-1:0] high,
                                  input logic [THRESH_W-1:0] low);
        wait_drained();
        write_threshold(CFG_PIN_HIGH, high);
        write_threshold(CFG_PIN_LOW, low);
    endtask

    // Field extremes, clamping, truncation and first-pin bookkeeping.
    task automatic test_directed();
        send_item(make_item(KIND_SAMPLE, 16'd0, 9'd0, 16'sh7fff, 16'hffff, 1'b0));
        send_item(make_item(KIND_SAMPLE, 16'hffff, 9'd511, 16'sh8000, 16'hffff, 1'b1));
        send_item(make_item(KIND_SAMPLE, 16'd1, 9'd7, -16'sd1, 16'd1, 1'b0));
        send_item(make_item(KIND_SAMPLE, 16'd2, 9'd7, 16'sd4096, UNITY_GAIN, 1'b0));
        send_item(make_item(KIND_SAMPLE, 16'd3, 9'd9, 16'sh7fff, 16'd0, 1'b0));
        send_item(make_item(KIND_SAMPLE, 16'd4, 9'd9, 16'sd16383, UNITY_GAIN, 1'b0));
        send_item(make_item(KIND_SAMPLE, 16'd4, 9'd9, 16'sd16382, UNITY_GAIN, 1'b0));
        send_item(make_item(KIND_SAMPLE, 16'd7, 9'd9, 16'sd8191, 16'd8192, 1'b0));
        send_item(make_item(KIND_SAMPLE, 16'd8, 9'd9, 16'sd1, 16'd4095, 1'b0));
        // A well that moves to an earlier flow, then refuses a later one.
        send_item(make_item(KIND_SAMPLE, 16'd5, 9'd20, -16'sd5, UNITY_GAIN, 1'b0));
        send_item(make_item(KIND_SAMPLE, 16'd5, 9'd10, -16'sd5, UNITY_GAIN, 1'b0));
        send_item(make_item(KIND_SAMPLE, 16'd5, 9'd30, -16'sd5, UNITY_GAIN, 1'b0));
        send_item(make_item(KIND_QUERY, 16'd5, 9'd20, 16'sd0, 16'd0, 1'b0));
        // A preset overrides the entry without touching any count.
        send_item(make_item(KIND_PRESET, 16'd5, 9'd10, 16'sd0, 16'd0, 1'b1));
        send_item(make_item(KIND_SAMPLE, 16'd5, 9'd3, 16'sh7fff, 16'hffff, 1'b0));
        send_item(make_item(KIND_PRESET, 16'd5, 9'd3, 16'sd0, 16'd0, 1'b0));
        send_item(make_item(KIND_SAMPLE, 16'd5, 9'd3, 16'sh7fff, 16'hffff, 1'b0));
        send_item(make_item(KIND_UNUSED, 16'd5, 9'd3, 16'sh7fff, 16'hffff, 1'b1));
        send_item(make_item(KIND_QUERY, 16'hffff, 9'd511, 16'sd0, 16'd0, 1'b0));
        // A well preset as pinned at flow zero keeps that entry against a later pin.
        send_item(make_item(KIND_PRESET, 16'd6, 9'd511, 16'sd0, 16'd0, 1'b1));
        send_item(make_item(KIND_SAMPLE, 16'd6, 9'd2, 16'sd0, 16'd0, 1'b0));
        send_item(make_item(KIND_QUERY, 16'd6, 9'd0, 16'sd0, 16'd0, 1'b0));
    endtask

    task automatic test_random_items(input int n_items);
        repeat (n_items) send_item(random_item());
    endtask

    // Random traffic with a full stop halfway until the output has drained.
    task automatic test_pause_midway(input int n_items);
        test_random_items(n_items / 2);
        wait_drained();
        test_random_items(n_items - n_items / 2);
    endtask

    // Each well walks down through the flows with mostly pinning samples.
    task automatic test_flow_sweeps(input int n_items);
        int          sent;
        int          f;
        logic [15:0] w;
        sent = 0;
        while (sent < n_items)
        begin
            w = SWEEP_WELL_BASE + 16'($urandom_range(7));
            if ($urandom_range(3) == 0)
            begin
                send_item(make_item(KIND_PRESET, w, '0, '0, '0, 1'($urandom_range(1))));
                sent++;
            end
            f = $urandom_range(60, 20);
            while (f >= 0 && sent < n_items)
            begin
                if ($urandom_range(99) < 15)
                    send_item(random_item());
                else if ($urandom_range(99) < 15)
                    send_item(make_item(KIND_QUERY, w, f[8:0], '0, '0, 1'b0));
                else
                    send_item(flow_sample(w, f[8:0], $urandom_range(99) < 70));
                sent++;
                f -= int'($urandom_range(6, 1));
            end
        end
    endtask

    // Receiver: pop changes at the falling edge, stalling at random when receiver_stalls is set.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= receiver_stalls ? ($urandom_range(99) >= 20) : 1'b1;
    end

    // Compare each result transfer with the oldest expected result.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result transfer with no expected result");
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_result.corrected_sample !== want.corrected_sample)
                    report_mismatch($sformatf("result %0d corrected_sample got %0d want %0d",
                        results_checked, $signed(out_result.corrected_sample),
                        $signed(want.corrected_sample)));
                if (out_result.out_of_range !== want.out_of_range)
                    report_mismatch($sformatf("result %0d out_of_range got %b want %b",
                        results_checked, out_result.out_of_range, want.out_of_range));
                if (out_result.flow_pin_count !== want.flow_pin_count)
                    report_mismatch($sformatf("result %0d flow_pin_count got %0d want %0d",
                        results_checked, out_result.flow_pin_count, want.flow_pin_count));
                if (out_result.well_pinned !== want.well_pinned)
                    report_mismatch($sformatf("result %0d well_pinned got %b want %b",
                        results_checked, out_result.well_pinned, want.well_pinned));
                if (out_result.first_flow !== want.first_flow)
                    report_mismatch($sformatf("result %0d first_flow got %0d want %0d",
                        results_checked, out_result.first_flow, want.first_flow));
            end
            results_checked++;
        end
    end

    // Watchdog: ends the run after a long stretch with no transfer at all.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles without a transfer", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_PIN_HIGH;
        cfg_data = '0;
        push = 1'b0;
        in_item = '0;
        mismatch_count = 0;
        items_sent = 0;
        results_checked = 0;
        threshold_writes = 0;
        earlier_moves = 0;
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        pin_high_thr = PIN_HIGH_RESET;
        pin_low_thr = PIN_LOW_RESET;
        foreach (first_pin[i])
            first_pin[i] = '0;
        foreach (flow_pins[i])
            flow_pins[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_items(200);
        set_thresholds('0, '1);
        test_random_items(60);
        // Long stretch with neither side idling.
        set_thresholds(14'd16380, 14'd100);
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        test_flow_sweeps(180);
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        set_thresholds(14'($urandom_range(16383)), 14'($urandom_range(16383)));
        test_pause_midway(200);
        set_thresholds(14'($urandom_range(16383, 8000)), 14'($urandom_range(7999)));
        test_random_items(100);
        wait_drained();

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                pending_results.size()));
        $display("Sent %0d items and checked %0d results over %0d threshold writes;",
            items_sent, results_checked, threshold_writes);
        $display("%0d pins moved a well to an earlier flow.", earlier_moves);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ppft_pkg.sv
rtl/core/ppft_ram.sv
rtl/core/ppft_fifo.sv
rtl/core/ppft_front.sv
rtl/core/ppft_back.sv
rtl/core/pinned_pixel_flow_tracker_core.sv
dv/tb_pinned_pixel_flow_tracker_core.sv
